// File: src/qsps_pkg.sv
// Shared types, constants and helper functions of the query string pair splitter.
package qsps_pkg;

    // Input beat: one raw byte of the query string
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_string;
    } in_beat_t;

    // Output beat: one decoded byte or an empty pair marker
    typedef struct packed {
        logic [7:0] char_out;
        logic       has_byte;
        logic       in_value;
        logic       pair_end;
        logic       overflow;
    } out_beat_t;

    // Special characters
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;

    // Configuration register map
    localparam int         PADDR_W        = 3;
    localparam logic [2:0] ADDR_KEEP_BLANK = 3'd0;

    // Percent escape phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HEX  = 2'd2
    } esc_phase_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_PUT   = 3'd1,
        ST_CLOSE = 3'd2,
        ST_READ  = 3'd3,
        ST_LOAD  = 3'd4,
        ST_MARK  = 3'd5
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       take;
        logic       put;
        logic [1:0] put_idx;
        logic       rd;
        logic       load;
        logic       mark;
        logic       clear;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] put_cnt;
        logic       close;
        logic       emit;
        logic       fill_zero;
        logic       rd_last;
        logic       out_free;
    } dp_status_t;

    // True for an ASCII hex digit
    function automatic logic hex_ok(input logic [7:0] c);
        hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Nibble value of an ASCII hex digit
    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        else
        begin
            v = c - 8'h37;
        end
        hex_nib = v[3:0];
    endfunction

endpackage

// File: src/qsps_ctrl.sv
// Controller state machine: sequences byte intake, buffer writes and pair readout.
module qsps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  qsps_pkg::dp_status_t status,
    output qsps_pkg::dp_cmd_t    cmd
);
    import qsps_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [1:0]  put_idx_reg, put_idx_next;
    logic        put_done;

    // State and put index registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            put_idx_reg <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            put_idx_reg <= put_idx_next;
        end
    end

    assign put_done = (status.put_cnt == 2'd0) || (put_idx_reg == status.put_cnt - 2'd1);

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        put_idx_next = put_idx_reg;
        cmd          = '0;
        cmd.put_idx  = put_idx_reg;
        in_stall     = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take     = 1'b1;
                    put_idx_next = 2'd0;
                    state_next   = ST_PUT;
                end
            end
            ST_PUT:
            begin
                cmd.put = (status.put_cnt != 2'd0);
                if (put_done)
                begin
                    state_next = status.close ? ST_CLOSE : ST_IDLE;
                end
                else
                begin
                    put_idx_next = put_idx_reg + 2'd1;
                end
            end
            ST_CLOSE:
            begin
                if (!status.emit)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.fill_zero)
                begin
                    state_next = ST_MARK;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    if (status.rd_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_MARK:
            begin
                if (status.out_free)
                begin
                    cmd.mark   = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/qsps_dp.sv
// Datapath: percent decoder, pair buffer memory, pair state and output register.
module qsps_dp #(
    parameter int PAIR_BYTES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qsps_pkg::in_beat_t   in_beat,
    input  logic                 keep_blank,
    input  qsps_pkg::dp_cmd_t    cmd,
    output qsps_pkg::dp_status_t status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output qsps_pkg::out_beat_t  out_beat
);
    import qsps_pkg::*;

    localparam int FILL_W = $clog2(PAIR_BYTES + 1);
    localparam int ADDR_W = $clog2(PAIR_BYTES);

    // Pair buffer: byte with its in_value tag
    logic [8:0] store_mem [PAIR_BYTES];
    logic [8:0] rd_data_reg;

    // Pending put list of the last accepted byte
    logic [7:0]  list_reg [4];
    logic [7:0]  list_next [4];
    logic [1:0]  cnt_reg, cnt_next;
    logic        tag_reg;
    logic        close_reg;

    // Pair state
    esc_phase_t  phase_reg, phase_next;
    logic [7:0]  digit_reg, digit_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] rd_ptr_reg;
    logic        rd_last_reg;
    logic        vstart_reg;
    logic        vseen_reg;
    logic        raw_seen_reg;
    logic        trunc_reg;
    logic        lost_reg;

    // Output register
    logic        out_valid_reg;
    out_beat_t   out_beat_reg;

    logic [7:0]  raw_c, dec_c, put_b;
    logic        is_sep, eq_first, do_flush;

    assign raw_c    = in_beat.char_in;
    assign dec_c    = (raw_c == CH_PLUS) ? CH_SPACE : raw_c;
    assign is_sep   = (raw_c == CH_AMP) || (raw_c == CH_SEMI);
    assign eq_first = (raw_c == CH_EQ) && !vstart_reg;
    assign do_flush = is_sep || eq_first || in_beat.end_of_string;
    assign put_b    = list_reg[cmd.put_idx];

    // Decode one raw byte into up to three buffer puts
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            list_next[i] = 8'h00;
        end
        cnt_next   = 2'd0;
        phase_next = phase_reg;
        digit_next = digit_reg;
        if (!is_sep && !eq_first && !trunc_reg)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (dec_c == CH_PCT)
                    begin
                        phase_next = PH_PCT;
                    end
                    else
                    begin
                        list_next[0] = dec_c;
                        cnt_next     = 2'd1;
                    end
                end
                PH_PCT:
                begin
                    if (hex_ok(dec_c))
                    begin
                        phase_next = PH_HEX;
                        digit_next = dec_c;
                    end
                    else
                    begin
                        list_next[0] = CH_PCT;
                        if (dec_c == CH_PCT)
                        begin
                            cnt_next = 2'd1;
                        end
                        else
                        begin
                            list_next[1] = dec_c;
                            cnt_next     = 2'd2;
                            phase_next   = PH_IDLE;
                        end
                    end
                end
                PH_HEX:
                begin
                    if (hex_ok(dec_c))
                    begin
                        list_next[0] = {hex_nib(digit_reg), hex_nib(dec_c)};
                        cnt_next     = 2'd1;
                        phase_next   = PH_IDLE;
                    end
                    else
                    begin
                        list_next[0] = CH_PCT;
                        list_next[1] = digit_reg;
                        if (dec_c == CH_PCT)
                        begin
                            cnt_next   = 2'd2;
                            phase_next = PH_PCT;
                        end
                        else
                        begin
                            list_next[2] = dec_c;
                            cnt_next     = 2'd3;
                            phase_next   = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        // Flush a pending escape literally at the end of a part
        if (do_flush)
        begin
            if (phase_next == PH_PCT)
            begin
                list_next[cnt_next] = CH_PCT;
                cnt_next            = cnt_next + 2'd1;
            end
            else if (phase_next == PH_HEX)
            begin
                list_next[cnt_next]         = CH_PCT;
                list_next[cnt_next + 2'd1]  = digit_next;
                cnt_next                    = cnt_next + 2'd2;
            end
            phase_next = PH_IDLE;
        end
    end

    // Capture the put list of an accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            for (int i = 0; i < 4; i++)
            begin
                list_reg[i] <= list_next[i];
            end
            tag_reg   <= vstart_reg;
            close_reg <= is_sep || in_beat.end_of_string;
            digit_reg <= digit_next;
        end
    end

    // Write buffer and read for readout
    always_ff @(posedge clk)
    begin
        if (cmd.put && !trunc_reg && put_b != 8'h00 && fill_reg < FILL_W'(PAIR_BYTES))
        begin
            store_mem[fill_reg[ADDR_W-1:0]] <= {tag_reg, put_b};
        end
        if (cmd.rd)
        begin
            rd_data_reg <= store_mem[rd_ptr_reg[ADDR_W-1:0]];
        end
    end

    // Pair control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= 2'd0;
            phase_reg    <= PH_IDLE;
            fill_reg     <= '0;
            rd_ptr_reg   <= '0;
            rd_last_reg  <= 1'b0;
            vstart_reg   <= 1'b0;
            vseen_reg    <= 1'b0;
            raw_seen_reg <= 1'b0;
            trunc_reg    <= 1'b0;
            lost_reg     <= 1'b0;
        end
        else if (cmd.clear)
        begin
            phase_reg    <= PH_IDLE;
            fill_reg     <= '0;
            rd_ptr_reg   <= '0;
            vstart_reg   <= 1'b0;
            vseen_reg    <= 1'b0;
            raw_seen_reg <= 1'b0;
            trunc_reg    <= 1'b0;
            lost_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                cnt_reg   <= cnt_next;
                phase_reg <= phase_next;
                if (!is_sep)
                begin
                    raw_seen_reg <= 1'b1;
                    if (eq_first)
                    begin
                        vstart_reg <= 1'b1;
                        trunc_reg  <= 1'b0;
                    end
                    else if (vstart_reg)
                    begin
                        vseen_reg <= 1'b1;
                    end
                end
            end
            // Apply one put: zero ends the part, a full buffer drops the byte
            if (cmd.put && !trunc_reg)
            begin
                if (put_b == 8'h00)
                begin
                    trunc_reg <= 1'b1;
                end
                else if (fill_reg < FILL_W'(PAIR_BYTES))
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
                else
                begin
                    lost_reg <= 1'b1;
                end
            end
            if (cmd.rd)
            begin
                rd_last_reg <= (rd_ptr_reg == fill_reg - FILL_W'(1));
                rd_ptr_reg  <= rd_ptr_reg + FILL_W'(1);
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load || cmd.mark)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_beat_reg.char_out <= rd_data_reg[7:0];
            out_beat_reg.has_byte <= 1'b1;
            out_beat_reg.in_value <= rd_data_reg[8];
            out_beat_reg.pair_end <= rd_last_reg;
            out_beat_reg.overflow <= lost_reg;
        end
        else if (cmd.mark)
        begin
            out_beat_reg.char_out <= 8'h00;
            out_beat_reg.has_byte <= 1'b0;
            out_beat_reg.in_value <= 1'b0;
            out_beat_reg.pair_end <= 1'b1;
            out_beat_reg.overflow <= lost_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // Status to controller
    assign status.put_cnt   = cnt_reg;
    assign status.close     = close_reg;
    assign status.emit      = raw_seen_reg && (keep_blank || vseen_reg);
    assign status.fill_zero = (fill_reg == '0);
    assign status.rd_last   = rd_last_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

endmodule

// File: src/query_string_pair_splitter.sv
// Sequence: idle takes a beat, then the put state writes each of its decoded bytes to the buffer.
// A closing beat then goes to the close state, then a memory read and output load per emitted byte,
// or a single empty pair marker; one beat is processed at a time.
// Reset: control state and keep_blank clear to zero; the pair buffer is not cleared.
module query_string_pair_splitter #(
    parameter int PAIR_BYTES = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  qsps_pkg::in_beat_t                    in_beat,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output qsps_pkg::out_beat_t                   out_beat,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [qsps_pkg::PADDR_W-1:0]          paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import qsps_pkg::*;

    logic       keep_blank_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_blank_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr == ADDR_KEEP_BLANK)
        begin
            keep_blank_reg <= pwdata[0];
        end
    end

    // Register readback
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_KEEP_BLANK) ? {31'd0, keep_blank_reg} : 32'd0;

    qsps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    qsps_dp #(
        .PAIR_BYTES (PAIR_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_beat    (in_beat),
        .keep_blank (keep_blank_reg),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_beat   (out_beat)
    );

endmodule

// File: bench/tb.sv
// Self-checking testbench of the query string pair splitter with a built-in pair predictor.
module tb;
    import qsps_pkg::*;

    localparam int BUF_DEPTH     = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_TIME    = 3_200_000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    in_beat_t            in_beat;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_beat_t           out_beat;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Stimulus control
    bit                  calm = 1'b0;
    int                  beats_sent = 0;
    int                  stall_hold = 0;
    int                  n_bad = 0;

    // Predicted output beats, oldest first
    out_beat_t           decoded_beats[$];
    out_beat_t           chk_want;

    // Predictor state of the pair being parsed
    logic [8:0]          pair_buf [0:BUF_DEPTH-1];
    int                  fill_cnt = 0;
    logic                in_value_part = 1'b0;
    int                  val_raw_len = 0;
    logic                raw_seen = 1'b0;
    esc_phase_t          esc = PH_IDLE;
    logic [7:0]          esc_digit = 8'h00;
    logic                part_cut = 1'b0;
    logic                bytes_lost = 1'b0;
    logic                keep_blank = 1'b0;

    query_string_pair_splitter #(
        .PAIR_BYTES(BUF_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #4 clk = ~clk;

    // Value of an ASCII hex digit, 16 for anything else
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c - "0");
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c - "a") + 10;
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c - "A") + 10;
        end
        return 16;
    endfunction

    // Append one decoded byte to the pair; a zero byte ends the part
    task automatic store_byte(input logic [7:0] b);
        if (!part_cut)
        begin
            if (b == 8'h00)
            begin
                part_cut = 1'b1;
            end
            else if (fill_cnt < BUF_DEPTH)
            begin
                pair_buf[fill_cnt] = {in_value_part, b};
                fill_cnt++;
            end
            else
            begin
                bytes_lost = 1'b1;
            end
        end
    endtask

    // Decode a byte with no escape pending
    task automatic decode_fresh(input logic [7:0] c);
        if (!part_cut)
        begin
            if (c == CH_PCT)
            begin
                esc = PH_PCT;
            end
            else
            begin
                store_byte(c);
            end
        end
    endtask

    // Advance the percent decoder by one byte; a broken escape stays literal
    task automatic decode_byte(input logic [7:0] c);
        logic [7:0] d;
        int         hi;
        int         lo;
        if (!part_cut)
        begin
            lo = hex_digit(c);
            case (esc)
                PH_IDLE:
                begin
                    decode_fresh(c);
                end
                PH_PCT:
                begin
                    if (lo < 16)
                    begin
                        esc       = PH_HEX;
                        esc_digit = c;
                    end
                    else
                    begin
                        store_byte(CH_PCT);
                        esc = PH_IDLE;
                        decode_fresh(c);
                    end
                end
                default:
                begin
                    hi = hex_digit(esc_digit);
                    if (lo < 16 && hi < 16)
                    begin
                        esc = PH_IDLE;
                        store_byte(8'(hi * 16 + lo));
                    end
                    else
                    begin
                        d = esc_digit;
                        store_byte(CH_PCT);
                        esc = PH_IDLE;
                        decode_fresh(d);
                        decode_fresh(c);
                    end
                end
            endcase
        end
    endtask

    // Write out a pending escape literally at the end of a part
    task automatic flush_pending();
        if (esc == PH_PCT)
        begin
            store_byte(CH_PCT);
        end
        else if (esc == PH_HEX)
        begin
            store_byte(CH_PCT);
            store_byte(esc_digit);
        end
        esc       = PH_IDLE;
        esc_digit = 8'h00;
    endtask

    // Close the pair: queue its beats if it is kept, then start afresh
    task automatic close_pair();
        out_beat_t o;
        flush_pending();
        if (raw_seen && (keep_blank || val_raw_len > 0))
        begin
            if (fill_cnt == 0)
            begin
                o          = '0;
                o.pair_end = 1'b1;
                o.overflow = bytes_lost;
                decoded_beats.push_back(o);
            end
            else
            begin
                for (int k = 0; k < fill_cnt; k++)
                begin
                    o.char_out = pair_buf[k][7:0];
                    o.has_byte = 1'b1;
                    o.in_value = pair_buf[k][8];
                    o.pair_end = (k == fill_cnt - 1);
                    o.overflow = bytes_lost;
                    decoded_beats.push_back(o);
                end
            end
        end
        fill_cnt      = 0;
        in_value_part = 1'b0;
        val_raw_len   = 0;
        raw_seen      = 1'b0;
        esc           = PH_IDLE;
        esc_digit     = 8'h00;
        part_cut      = 1'b0;
        bytes_lost    = 1'b0;
    endtask

    // Predict the effect of one accepted input beat
    task automatic parse_query_byte(input in_beat_t b);
        logic sep;
        sep = (b.char_in == CH_AMP) || (b.char_in == CH_SEMI);
        if (!sep)
        begin
            raw_seen = 1'b1;
            if (b.char_in == CH_EQ && !in_value_part)
            begin
                flush_pending();
                in_value_part = 1'b1;
                part_cut      = 1'b0;
            end
            else
            begin
                if (in_value_part && val_raw_len < 127)
                begin
                    val_raw_len++;
                end
                decode_byte((b.char_in == CH_PLUS) ? CH_SPACE : b.char_in);
            end
        end
        if (sep || b.end_of_string)
        begin
            close_pair();
        end
    endtask

    // Idle length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return $urandom_range(1, 2);
        end
        if (r < 92)
        begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(16, 48);
    endfunction

    function automatic logic [7:0] hex_char();
        int i;
        i = $urandom_range(0, 21);
        if (i < 10)
        begin
            return 8'(8'h30 + i);
        end
        if (i < 16)
        begin
            return 8'(8'h61 + i - 10);
        end
        return 8'(8'h41 + i - 16);
    endfunction

    // Content byte; noisy mode adds zero bytes and stray separators
    function automatic logic [7:0] rand_char(input bit noisy);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            return 8'(8'h61 + $urandom_range(0, 25));
        end
        if (r < 45)
        begin
            return hex_char();
        end
        if (r < 55)
        begin
            return CH_PCT;
        end
        if (r < 63)
        begin
            return CH_PLUS;
        end
        if (r < 68)
        begin
            return CH_EQ;
        end
        if (r < 74)
        begin
            if (!noisy)
            begin
                return "x";
            end
            if (r < 70)
            begin
                return 8'h00;
            end
            return ($urandom_range(0, 1) == 0) ? CH_AMP : CH_SEMI;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_part_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 5);
        end
        return $urandom_range(6, 12);
    endfunction

    // Send one beat, after a random gap, and predict it once accepted
    task automatic send_beat(input logic [7:0] c, input logic eos);
        in_beat_t b;
        int       gap;
        b.char_in       = c;
        b.end_of_string = eos;
        gap = 0;
        if (!calm && $urandom_range(0, 1) == 0)
        begin
            gap = gap_len();
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        parse_query_byte(b);
        beats_sent++;
    endtask

    task automatic send_text(input string s, input bit eos_on_last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_beat(s[i], eos_on_last && (i == s.len() - 1));
        end
    endtask

    // Send about len raw bytes of one key or value, escapes included
    task automatic send_part(input int len, input bit noisy);
        int   i;
        logic eos;
        i = 0;
        while (i < len)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                send_beat(CH_PCT, 1'b0);
                if (noisy && $urandom_range(0, 9) == 0)
                begin
                    send_beat("0", 1'b0);
                    send_beat("0", 1'b0);
                end
                else
                begin
                    send_beat(hex_char(), 1'b0);
                    send_beat(hex_char(), 1'b0);
                end
                i += 3;
            end
            else
            begin
                eos = noisy && ($urandom_range(0, 99) < 2);
                send_beat(rand_char(noisy), eos);
                i++;
            end
        end
    endtask

    // Send whole pairs until n_items beats went out; the last one ends the string
    task automatic send_query(input int n_items);
        int         start;
        logic [7:0] sep;
        start = beats_sent;
        while (beats_sent - start < n_items)
        begin
            send_part(pick_part_len(), 1'b1);
            if ($urandom_range(0, 99) < 85)
            begin
                send_beat(CH_EQ, 1'b0);
                send_part(pick_part_len(), 1'b1);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_beat(CH_AMP, 1'b0);
            end
            sep = ($urandom_range(0, 1) == 0) ? CH_AMP : CH_SEMI;
            send_beat(sep, (beats_sent + 1 - start >= n_items) || ($urandom_range(0, 99) < 4));
        end
    endtask

    // Drop valid and wait until every predicted beat came out and the block went quiet
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (decoded_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write keep_blank over the register port and read it back
    task automatic set_keep_blank(input logic v);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_KEEP_BLANK;
        pwdata  <= {31'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        keep_blank = v;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {31'b0, v})
        begin
            n_bad++;
            if (n_bad <= 10)
            begin
                $display("keep_blank readback: expected %h, got %h", {31'b0, v}, rd);
            end
        end
    endtask

    task automatic flag_beat(input string what, input out_beat_t want, input out_beat_t got);
        n_bad++;
        if (n_bad <= 10)
        begin
            $display("%s: expected char=%h has_byte=%b in_value=%b pair_end=%b overflow=%b",
                     what, want.char_out, want.has_byte, want.in_value, want.pair_end,
                     want.overflow);
            $display("    got char=%h has_byte=%b in_value=%b pair_end=%b overflow=%b",
                     got.char_out, got.has_byte, got.in_value, got.pair_end, got.overflow);
        end
    endtask

    // Directed strings: escapes, separators, zero bytes, blank values
    task automatic test_directed();
        set_keep_blank(1'b0);
        // broken escapes in the key, good escape and plus in the value
        send_text("k%z%4g=%41+;", 1'b0);
        // dropped blank value, then an empty pair
        send_text("e=&;", 1'b0);
        // all-ones byte, raw zero in the key, decoded zero in the value
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_text("z=%00q", 1'b1);
        wait_idle();
        set_keep_blank(1'b1);
        // kept pair with nothing decoded, then separator that ends the string
        send_text("=&", 1'b0);
        send_text("n;", 1'b1);
    endtask

    // Random pairs under both settings, one phase without any idling
    task automatic test_random_pairs();
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            set_keep_blank(p[0] == 1'b0);
            calm = (p == 2);
            send_query(34);
        end
        calm = 1'b0;
    endtask

    // Pairs that run past the buffer, in the key and in the value
    task automatic test_long_pairs();
        wait_idle();
        set_keep_blank(1'b0);
        send_part($urandom_range(90, 110), 1'b0);
        send_beat(CH_EQ, 1'b0);
        send_part($urandom_range(0, 2), 1'b0);
        send_beat(CH_AMP, 1'b0);
        send_text("a=b", 1'b1);
        wait_idle();
        set_keep_blank(1'b1);
        send_text("k=", 1'b0);
        send_part($urandom_range(90, 110), 1'b0);
        send_beat(CH_SEMI, 1'b1);
    endtask

    // Output stall: runs of flow, then stalls of random length
    always @(posedge clk)
    begin
        if (calm || !rst_n)
        begin
            out_stall <= 1'b0;
            stall_hold = 0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold = stall_hold - 1;
        end
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            stall_hold = $urandom_range(0, 15);
        end
        else
        begin
            out_stall <= 1'b1;
            stall_hold = gap_len() - 1;
        end
    end

    // Compare each accepted output beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_beats.size() == 0)
            begin
                flag_beat("unexpected beat", '0, out_beat);
            end
            else
            begin
                chk_want = decoded_beats.pop_front();
                if (out_beat.char_out !== chk_want.char_out ||
                    out_beat.has_byte !== chk_want.has_byte ||
                    out_beat.in_value !== chk_want.in_value ||
                    out_beat.pair_end !== chk_want.pair_end ||
                    out_beat.overflow !== chk_want.overflow)
                begin
                    flag_beat("beat mismatch", chk_want, out_beat);
                end
            end
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_beat  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_pairs();
        test_long_pairs();
        wait_idle();
        if (n_bad == 0 && decoded_beats.size() == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #LIMIT_TIME;
        $display("tb failed");
        $finish;
    end

endmodule

// File: files.f
src/qsps_pkg.sv
src/qsps_ctrl.sv
src/qsps_dp.sv
src/query_string_pair_splitter.sv
bench/tb.sv
